### hw/rtl/dsdp_pkg.sv
`timescale 1ns / 1ps

package dsdp_pkg;

  localparam int NUM_DIODES    = 8;
  localparam int VECTOR_LENGTH = 16;
  localparam int DATA_WIDTH    = 32;

  localparam int ROWS      = 2 * NUM_DIODES;
  localparam int FRAC_BITS = 16;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 8;
  localparam int ELEM_W    = $clog2(VECTOR_LENGTH);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int DIODE_W   = $clog2(STATUS_W);
  localparam int PROD_W    = 2 * VALUE_W;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  // what a sample beat does to the running sums
  typedef enum logic [1:0] {
    MODE_HOLD    = 2'd0,
    MODE_RESTART = 2'd1,
    MODE_ADD     = 2'd2
  } mode_e;

  // beat travelling down the row chain
  typedef struct packed {
    logic                         valid;
    op_e                          op;
    logic [VALUE_W-1:0]           value;
    logic                         last;
    mode_e                        mode;
    logic [ELEM_W-1:0]            addr;
    logic [ROW_W-1:0]             row;
    logic signed [DATA_WIDTH-1:0] psum;
    logic [STATUS_W-1:0]          status;
  } beat_t;

endpackage

### hw/rtl/dsdp_if.sv
`timescale 1ns / 1ps

interface dsdp_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [dsdp_pkg::VALUE_W-1:0] value;
  logic                         first;
  logic                         last;

  modport source (output valid, output op, output value, output first, output last,
                  input ready);
  modport sink   (input valid, input op, input value, input first, input last,
                  output ready);
endinterface

interface dsdp_out_if;
  logic                          valid;
  logic                          ready;
  logic [dsdp_pkg::STATUS_W-1:0] on_mask;

  modport source (output valid, output on_mask, input ready);
  modport sink   (input valid, input on_mask, output ready);
endinterface

### hw/rtl/diode_state_dot_product_update_core.sv
`timescale 1ns / 1ps

// Diode state update by per-row dot products. One beat is accepted every
// cycle, loads and samples alike; the chain stops only when a status result
// reaches its end while the previous result still waits in the output
// register. Each beat walks a chain of 2*NUM_DIODES row cells, each cell
// registering it through coefficient read, multiply and accumulate steps,
// and a status passes the output register after the last cell. Row 2*i is
// diode i's off row, row 2*i+1 its on row; the odd cell decides the diode
// using the even neighbor's sum carried in the beat. Coefficients are
// undefined until loaded; no clearing pass is run.

module diode_state_dot_product_update_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  dsdp_in_if.sink         in_i,
  dsdp_out_if.source      out_o
);

  dsdp_pkg::beat_t chain [dsdp_pkg::ROWS+1];
  dsdp_pkg::beat_t head, tail;

  logic [dsdp_pkg::ELEM_W-1:0] elem_q;
  logic [dsdp_pkg::ROW_W-1:0]  row_q;
  logic                        en, in_fire, tail_emit;
  logic                        out_valid_q;
  logic [dsdp_pkg::STATUS_W-1:0] status_q;

  // chain holds only when a second result would overrun the output register
  assign tail      = chain[dsdp_pkg::ROWS];
  assign tail_emit = tail.valid && (tail.op == dsdp_pkg::OP_SAMPLE) && tail.last;
  assign en        = !(tail_emit && out_valid_q && !out_o.ready);
  assign in_i.ready = en;
  assign in_fire   = in_i.valid && en;

  // head beat: element position and saturation resolved once, here
  always_comb begin
    head        = '0;
    head.valid  = in_fire;
    head.op     = dsdp_pkg::op_e'(in_i.op);
    head.value  = in_i.value;
    head.last   = in_i.last;
    head.row    = row_q;
    if (in_i.first) begin
      head.mode = dsdp_pkg::MODE_RESTART;
      head.addr = '0;
    end else if ((dsdp_pkg::ELEM_W+1)'(elem_q) + 1'b1 <
                 (dsdp_pkg::ELEM_W+1)'(dsdp_pkg::VECTOR_LENGTH)) begin
      head.mode = dsdp_pkg::MODE_ADD;
      head.addr = elem_q + 1'b1;
    end else begin
      head.mode = dsdp_pkg::MODE_HOLD;  // past the vector end
      head.addr = elem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q <= '0;
      row_q  <= '0;
    end else if (in_fire) begin
      if (head.op == dsdp_pkg::OP_SAMPLE) begin
        elem_q <= head.addr;
      end else if (head.last) begin
        row_q <= (row_q == dsdp_pkg::ROW_W'(dsdp_pkg::ROWS - 1)) ? '0 : row_q + 1'b1;
      end
    end
  end

  assign chain[0] = head;

  for (genvar g = 0; g < dsdp_pkg::ROWS; g++) begin : g_cell
    dsdp_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .cell_idx_i (dsdp_pkg::ROW_W'(g)),
      .beat_i     (chain[g]),
      .beat_o     (chain[g+1])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && tail_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && tail_emit) begin
      status_q <= tail.status;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.on_mask = status_q;

`ifndef SYNTH
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_emit && out_valid_q && !out_o.ready) |-> !in_fire)
    else $error("input beat taken while result would overrun output");

  a_elem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dsdp_pkg::ELEM_W+1)'(elem_q) < (dsdp_pkg::ELEM_W+1)'(dsdp_pkg::VECTOR_LENGTH))
    else $error("element position out of range");

  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.op == dsdp_pkg::OP_LOAD && in_i.last) |=> (row_q != $past(row_q)))
    else $error("row did not advance after closing load");
`endif

endmodule

### hw/rtl/dsdp_cell.sv
`timescale 1ns / 1ps

module dsdp_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [dsdp_pkg::ROW_W-1:0] cell_idx_i,
  input  dsdp_pkg::beat_t           beat_i,
  output dsdp_pkg::beat_t           beat_o
);

  function automatic logic sum_positive(input logic signed [dsdp_pkg::DATA_WIDTH-1:0] s);
    sum_positive = !s[dsdp_pkg::DATA_WIDTH-1] && (s != '0);
  endfunction

  logic [dsdp_pkg::VALUE_W-1:0] mem_q [dsdp_pkg::VECTOR_LENGTH];
  logic [dsdp_pkg::VALUE_W-1:0] coef_q;
  logic [dsdp_pkg::ELEM_W-1:0]  fill_q, fill_d;

  dsdp_pkg::beat_t beat_a_q, beat_b_q, beat_c_q, beat_c_d;

  logic signed [dsdp_pkg::PROD_W-1:0]     prod_full, prod_shift;
  logic signed [dsdp_pkg::DATA_WIDTH-1:0] prod_q, prod_d;
  logic signed [dsdp_pkg::DATA_WIDTH-1:0] sum_q, sum_d;
  logic                                   on_q, next_on;
  logic                                   wr_en, odd_cell, sample_b;
  logic [dsdp_pkg::DIODE_W-1:0]           diode_idx;

  assign odd_cell  = cell_idx_i[0];
  assign diode_idx = dsdp_pkg::DIODE_W'(cell_idx_i >> 1);
  assign wr_en     = en_i && beat_i.valid && (beat_i.op == dsdp_pkg::OP_LOAD) &&
                     (beat_i.row == cell_idx_i);
  assign fill_d    = (fill_q == dsdp_pkg::ELEM_W'(dsdp_pkg::VECTOR_LENGTH - 1)) ?
                     '0 : fill_q + 1'b1;

  // coefficient row: write on load beats for this row, registered read per beat
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[fill_q] <= beat_i.value;
    end
    if (en_i && beat_i.valid) begin
      coef_q <= mem_q[beat_i.addr];
    end
  end

  assign prod_full  = $signed(coef_q) * $signed(beat_a_q.value);
  assign prod_shift = prod_full >>> dsdp_pkg::FRAC_BITS;
  assign prod_d     = prod_shift[dsdp_pkg::DATA_WIDTH-1:0];

  assign sample_b = beat_b_q.valid && (beat_b_q.op == dsdp_pkg::OP_SAMPLE);

  always_comb begin
    case (beat_b_q.mode)
      dsdp_pkg::MODE_RESTART: sum_d = prod_q;
      dsdp_pkg::MODE_ADD:     sum_d = sum_q + prod_q;
      default:                sum_d = sum_q;
    endcase
  end

  // odd cell owns the diode: on uses its own row, off uses the even neighbor's
  assign next_on = on_q ? sum_positive(sum_d) : sum_positive(beat_b_q.psum);

  always_comb begin
    beat_c_d = beat_b_q;
    if (!odd_cell) begin
      beat_c_d.psum = sum_d;
    end else if (sample_b && beat_b_q.last) begin
      beat_c_d.status[diode_idx] = next_on;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      beat_a_q <= '0;
      beat_b_q <= '0;
      beat_c_q <= '0;
      sum_q    <= '0;
      on_q     <= 1'b0;
    end else if (en_i) begin
      if (wr_en) begin
        fill_q <= fill_d;
      end
      beat_a_q <= beat_i;
      beat_b_q <= beat_a_q;
      beat_c_q <= beat_c_d;
      if (sample_b) begin
        sum_q <= sum_d;
      end
      if (odd_cell && sample_b && beat_b_q.last) begin
        on_q <= next_on;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign beat_o = beat_c_q;

endmodule

### sim/diode_state_dot_product_update_core_tb.sv
`timescale 1ns / 1ps

module diode_state_dot_product_update_core_tb;
  import dsdp_pkg::*;

  localparam int RAND_BEATS   = 1170;
  localparam int MAX_GAP      = 17;
  localparam int LONG_HOLD    = 600;     // cycles the status sink stays blocked once
  localparam int LONG_HOLD_AT = 40;      // status count that triggers the long hold
  localparam int DRAIN_FIRST  = 800;     // random beat index of the first sender drain
  localparam int DRAIN_EVERY  = 400;
  localparam int LATENCY      = 3 * ROWS + 1;
  localparam int CYCLE_LIMIT  = 300000;

  // one input beat plus the sender's idle cycles in front of it
  typedef struct {
    op_e                op;
    logic [VALUE_W-1:0] value;
    logic               first;
    logic               last;
    int unsigned        gap;
    bit                 drain;   // hold this beat until no status is outstanding
  } stim_beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dsdp_in_if  in_if ();
  dsdp_out_if out_if ();

  diode_state_dot_product_update_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow copy of the diode block: coefficient rows, load pointers, one
  // running sum per row, the shared element pointer and the on/off bits.
  // ---------------------------------------------------------------------------
  logic [VALUE_W-1:0]           coef_mem [ROWS][VECTOR_LENGTH];
  int unsigned                  fill_pos [ROWS];
  int unsigned                  load_row;
  logic signed [DATA_WIDTH-1:0] row_sum  [ROWS];
  int unsigned                  elem_pos;
  logic [STATUS_W-1:0]          diode_bits;

  logic [STATUS_W-1:0] pending_status [$];   // statuses predicted, not yet seen
  stim_beat_t          beats_to_send  [$];

  int unsigned beats_queued;
  int unsigned beats_accepted;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned cycle_count;
  int          idle_style;   // sender: 0 no gaps, 1 sparse gaps, 2 random gap on every beat
  int          sink_style;   // same scheme for the status sink
  bit          drain_next;

  // Q16.16 product: exact 64-bit result, floor shift by the fraction, then
  // wrapped to the accumulator width.
  function automatic logic signed [DATA_WIDTH-1:0] scaled_term(
    input logic signed [VALUE_W-1:0] coef,
    input logic signed [VALUE_W-1:0] sample
  );
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] shifted;
    prod    = coef * sample;
    shifted = prod >>> FRAC_BITS;
    return shifted[DATA_WIDTH-1:0];
  endfunction

  // Applies one accepted beat to the shadow copy; a closing sample queues the
  // status the block must produce for it.
  task automatic advance_diode_model(input stim_beat_t b);
    logic signed [DATA_WIDTH-1:0] pick;
    if (b.op == OP_LOAD) begin
      coef_mem[load_row][fill_pos[load_row]] = b.value;
      fill_pos[load_row] = (fill_pos[load_row] + 1) % VECTOR_LENGTH;
      // the next row keeps its own fill position
      if (b.last) load_row = (load_row + 1) % ROWS;
    end else begin
      if (b.first) begin
        elem_pos = 0;
        for (int r = 0; r < ROWS; r++) row_sum[r] = scaled_term(coef_mem[r][0], b.value);
      end else if (elem_pos + 1 < VECTOR_LENGTH) begin
        elem_pos++;
        for (int r = 0; r < ROWS; r++)
          row_sum[r] = row_sum[r] + scaled_term(coef_mem[r][elem_pos], b.value);
      end
      // past the vector end the pointer saturates and the sample adds nothing
      if (b.last) begin
        for (int d = 0; d < NUM_DIODES; d++) begin
          pick = diode_bits[d] ? row_sum[2*d+1] : row_sum[2*d];
          diode_bits[d] = (pick > 0);
        end
        pending_status.push_back(diode_bits);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0000;
          3:       v = 32'hFFFF_FFFF;
          default: v = 32'h0001_0000;
        endcase
      end
      // small values, about +-8.0, so sums keep a meaningful sign
      1, 2, 3: v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic int unsigned pick_gap(input int style);
    int unsigned g;
    case (style)
      0:       g = 0;
      1:       g = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
      default: g = $urandom_range(0, MAX_GAP);
    endcase
    return g;
  endfunction

  task automatic queue_beat(
    input op_e                op,
    input logic [VALUE_W-1:0] value,
    input logic               first,
    input logic               last
  );
    stim_beat_t b;
    b.op    = op;
    b.value = value;
    b.first = first;
    b.last  = last;
    b.gap   = pick_gap(idle_style);
    b.drain = drain_next;
    drain_next = 1'b0;
    beats_to_send.push_back(b);
    beats_queued++;
  endtask

  // well-formed vector: first on the opening sample, last on the closing one
  task automatic queue_vector(input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      queue_beat(OP_SAMPLE, pick_value(), i == 0, i == len - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued beats, waits out each beat's gap, holds the beat
  // while ready is low. The model is updated on the accepting edge.
  // ---------------------------------------------------------------------------
  stim_beat_t  on_bus;
  stim_beat_t  staged_beat;
  bit          staged;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.op    <= OP_LOAD;
      in_if.value <= '0;
      in_if.first <= 1'b0;
      in_if.last  <= 1'b0;
      staged      = 1'b0;
      gap_left    = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        advance_diode_model(on_bus);
        beats_accepted++;
      end
      // a beat still waiting for ready stays on the bus untouched
      if (!(in_if.valid && !in_if.ready)) begin
        if (!staged && beats_to_send.size() != 0 &&
            (!beats_to_send[0].drain || pending_status.size() == 0)) begin
          staged_beat = beats_to_send.pop_front();
          gap_left    = staged_beat.gap;
          staged      = 1'b1;
        end
        if (staged && gap_left == 0) begin
          on_bus      = staged_beat;
          staged      = 1'b0;
          in_if.valid <= 1'b1;
          in_if.op    <= staged_beat.op;
          in_if.value <= staged_beat.value;
          in_if.first <= staged_beat.first;
          in_if.last  <= staged_beat.last;
        end else begin
          if (staged) gap_left--;
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Status sink: checks each status beat against the oldest prediction and
  // draws a stall after each one. Once, it blocks for a long stretch so the
  // block's output register and row chain back up into the input.
  // ---------------------------------------------------------------------------
  int unsigned         stall_left;
  logic [STATUS_W-1:0] want_status;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left   = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (pending_status.size() == 0) begin
          $display("%0t: on_mask mismatch, expected none, actual %02h",
                   $time, out_if.on_mask);
          error_count++;
        end else begin
          want_status = pending_status.pop_front();
          if (out_if.on_mask !== want_status) begin
            $display("%0t: on_mask mismatch, expected %02h, actual %02h",
                     $time, want_status, out_if.on_mask);
            error_count++;
          end
        end
        if (results_seen == LONG_HOLD_AT) stall_left = LONG_HOLD;
        else stall_left = pick_gap(sink_style);
        if ($urandom_range(0, 15) == 0) sink_style = $urandom_range(0, 2);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_if.ready <= (stall_left == 0);
    end
  end

  // watchdog
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("diode_state_dot_product_update_core_tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus build, reset, end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned rand_start;
    int unsigned next_drain;
    logic [VALUE_W-1:0] v;

    for (int r = 0; r < ROWS; r++) begin
      fill_pos[r] = 0;
      row_sum[r]  = '0;
    end
    load_row       = 0;
    elem_pos       = 0;
    diode_bits     = '0;
    beats_queued   = 0;
    beats_accepted = 0;
    results_seen   = 0;
    error_count    = 0;
    drain_next     = 1'b0;
    idle_style     = 1;
    sink_style     = 1;

    // Every sample reads one coefficient of every row, so all rows are filled
    // before the first sample. Row ends carry last; the final one wraps the
    // row pointer back to row 0. Load beats ignore first, so it is random.
    for (int r = 0; r < ROWS; r++) begin
      for (int e = 0; e < VECTOR_LENGTH; e++) begin
        if (r == 0 && e == 0) v = 32'h7FFF_FFFF;
        else if (r == 1 && e == 0) v = 32'h8000_0000;
        else v = pick_value();
        queue_beat(OP_LOAD, v, 1'($urandom_range(0, 1)), e == VECTOR_LENGTH - 1);
      end
    end

    // directed: extreme samples that open and close a vector in one beat
    queue_beat(OP_SAMPLE, 32'h7FFF_FFFF, 1'b1, 1'b1);
    queue_beat(OP_SAMPLE, 32'h8000_0000, 1'b1, 1'b1);
    // closing sample without first: continues at the next element
    queue_beat(OP_SAMPLE, 32'hFFFF_FFFF, 1'b0, 1'b1);
    // vector two samples too long; the extra ones must add nothing
    for (int i = 0; i < VECTOR_LENGTH + 2; i++)
      queue_beat(OP_SAMPLE, pick_value(), i == 0, i == VECTOR_LENGTH + 1);
    // row switch in the middle of a row, then a one-beat vector
    queue_beat(OP_LOAD, 32'h0000_0000, 1'b0, 1'b0);
    queue_beat(OP_LOAD, 32'h8000_0000, 1'b1, 1'b1);
    queue_beat(OP_SAMPLE, 32'h0001_0000, 1'b1, 1'b1);

    // random part: mostly well-formed vectors, some load bursts and noise
    rand_start = beats_queued;
    next_drain = DRAIN_FIRST;
    while (beats_queued - rand_start < RAND_BEATS) begin
      if ($urandom_range(0, 15) == 0) idle_style = $urandom_range(0, 2);
      if (beats_queued - rand_start >= next_drain) begin
        drain_next = 1'b1;
        next_drain += DRAIN_EVERY;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          if ($urandom_range(0, 5) == 0)
            queue_vector($urandom_range(VECTOR_LENGTH + 1, VECTOR_LENGTH + 8));
          else
            queue_vector($urandom_range(1, VECTOR_LENGTH));
        end
        7: begin
          repeat ($urandom_range(1, 8))
            queue_beat(OP_LOAD, pick_value(), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 3) == 0);
        end
        8: begin
          queue_beat(op_e'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
        end
        default: begin
          // broken vector: flags scattered at random
          repeat ($urandom_range(1, 5))
            queue_beat(OP_SAMPLE, pick_value(), $urandom_range(0, 3) == 0,
                       $urandom_range(0, 3) == 0);
        end
      endcase
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_accepted != beats_queued) @(posedge clk_i);
    while (pending_status.size() != 0) @(posedge clk_i);
    // catch any status beat beyond the predicted ones
    repeat (LATENCY + 16) @(posedge clk_i);

    if (error_count == 0) begin
      $display("diode_state_dot_product_update_core_tb: done, clean");
    end else begin
      $display("diode_state_dot_product_update_core_tb: done, errors");
    end
    $finish;
  end

endmodule
